>>> hw/rtl/quad_batch_vertex_expander_assert.svh
// Assertion macros shared by the quad batch vertex expander RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef QUAD_BATCH_VERTEX_EXPANDER_ASSERT_SVH
`define QUAD_BATCH_VERTEX_EXPANDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBVE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qbve: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define QBVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qbve: next-cycle check failed");

// The condition must never be seen outside reset.
`define QBVE_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("qbve: forbidden condition seen");

`endif

>>> hw/rtl/qbve_pkg.sv
// Shared types and constants of the quad batch vertex expander.
// Depends on nothing; imported by every module of the block.
package qbve_pkg;

  localparam int unsigned MAX_QUADS        = 1024;
  localparam int unsigned MAX_SLOTS        = 32;
  localparam int unsigned INDICES_PER_QUAD = 6;
  localparam int unsigned CORNERS          = 4;
  localparam int unsigned INDEX_LIMIT      = INDICES_PER_QUAD * MAX_QUADS;

  localparam int unsigned COUNT_W      = $clog2(INDEX_LIMIT + 1);
  localparam int unsigned NFS_W        = 6;
  localparam int unsigned SLOT_IDX_W   = $clog2(MAX_SLOTS);
  localparam int unsigned SLOT_W       = 5;
  localparam int unsigned DRAW_COUNT_W = 13;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned CORNER_W     = $clog2(CORNERS);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] WHITE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_COLORED  = 2'd0,
    OP_TEXTURED = 2'd1,
    OP_FLUSH    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_BIND   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  size_x;
    logic signed [COORD_W-1:0]  size_y;
    logic [7:0]                 color_red;
    logic [7:0]                 color_green;
    logic [7:0]                 color_blue;
    logic [7:0]                 color_alpha;
    logic [31:0]                texture_handle;
  } in_item_t;

  typedef struct packed {
    kind_e                      kind;
    logic signed [COORD_W-1:0]  vertex_x;
    logic signed [COORD_W-1:0]  vertex_y;
    logic [31:0]                vertex_color;
    logic                       corner_u;
    logic                       corner_v;
    logic [SLOT_W-1:0]          slot_number;
    logic [31:0]                bound_handle;
    logic [DRAW_COUNT_W-1:0]    draw_index_count;
    logic                       last_result;
  } out_item_t;

  // One classified command as handed from the front end to the back end.
  typedef struct packed {
    logic                       need_draw;
    logic [DRAW_COUNT_W-1:0]    draw_count;
    logic                       need_bind;
    logic                       is_quad;
    logic [SLOT_W-1:0]          slot;
    logic [31:0]                handle;
    logic [31:0]                color;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  size_x;
    logic signed [COORD_W-1:0]  size_y;
  } job_t;

endpackage

>>> hw/rtl/qbve_front.sv
// Front end: accepts commands, tracks batch state and resolves texture slots.
// Depends on qbve_pkg and the assertion macro header.
`include "quad_batch_vertex_expander_assert.svh"

module qbve_front import qbve_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output job_t     job_o,
  input  logic     queue_full_i
);

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MATCH,
    FS_PUSH
  } fstate_e;

  fstate_e                state_q, state_d;
  in_item_t               item_q;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [NFS_W-1:0]       nfs_q, nfs_d;
  logic [MAX_SLOTS-1:0]   match_q, match_d;
  logic                   draw_q, draw_d;
  logic [31:0]            handles_q [MAX_SLOTS];

  logic                   is_quad, is_tex, is_flush, full, hit, tbl_we;
  logic [NFS_W-1:0]       match_nfs, base_nfs, hit_slot, slot_sel;
  logic [COUNT_W-1:0]     base_count;

  assign is_quad  = (item_q.opcode == OP_COLORED) || (item_q.opcode == OP_TEXTURED);
  assign is_tex   = (item_q.opcode == OP_TEXTURED);
  assign is_flush = (item_q.opcode == OP_FLUSH);

  // A full batch is closed before the new quad is added.
  assign full = (count_q >= COUNT_W'(INDEX_LIMIT)) ||
                (is_tex && ({1'b0, nfs_q} >= (NFS_W + 1)'(MAX_SLOTS)));
  assign draw_d    = is_flush || (is_quad && full);
  assign match_nfs = draw_d ? NFS_W'(1) : nfs_q;

  // Compare the handle against every live slot; the result is registered.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      match_d[i] = (i != 0) && (NFS_W'(i) < match_nfs) &&
                   (handles_q[i] == item_q.texture_handle);
    end
  end

  assign hit = |match_q;

  always_comb begin
    hit_slot = '0;
    for (int i = MAX_SLOTS - 1; i > 0; i--) begin
      if (match_q[i]) begin
        hit_slot = NFS_W'(i);
      end
    end
  end

  assign base_nfs   = draw_q ? NFS_W'(1) : nfs_q;
  assign base_count = draw_q ? '0 : count_q;
  assign slot_sel   = !is_tex ? '0 : (hit ? hit_slot : base_nfs);

  assign in_stall_o = (state_q != FS_IDLE);
  assign push_o     = (state_q == FS_PUSH) && !queue_full_i && (is_quad || is_flush);
  assign tbl_we     = push_o && is_tex && !hit;

  always_comb begin
    job_o.need_draw  = draw_q;
    job_o.draw_count = DRAW_COUNT_W'(count_q);
    job_o.need_bind  = is_tex && !hit;
    job_o.is_quad    = is_quad;
    job_o.slot       = slot_sel[SLOT_W-1:0];
    job_o.handle     = is_tex ? item_q.texture_handle : '0;
    job_o.color      = is_tex ? WHITE : {item_q.color_red, item_q.color_green,
                                         item_q.color_blue, item_q.color_alpha};
    job_o.pos_x      = item_q.pos_x;
    job_o.pos_y      = item_q.pos_y;
    job_o.size_x     = item_q.size_x;
    job_o.size_y     = item_q.size_y;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    nfs_d   = nfs_q;
    unique case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          state_d = FS_MATCH;
        end
      end
      FS_MATCH: begin
        state_d = FS_PUSH;
      end
      FS_PUSH: begin
        if (!(is_quad || is_flush)) begin
          state_d = FS_IDLE;
        end else if (!queue_full_i) begin
          state_d = FS_IDLE;
          if (is_flush) begin
            count_d = '0;
            nfs_d   = NFS_W'(1);
          end else begin
            count_d = base_count + COUNT_W'(INDICES_PER_QUAD);
            nfs_d   = (is_tex && !hit) ? base_nfs + NFS_W'(1) : base_nfs;
          end
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      count_q <= '0;
      nfs_q   <= NFS_W'(1);
      match_q <= '0;
      draw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      nfs_q   <= nfs_d;
      if (state_q == FS_MATCH) begin
        match_q <= match_d;
        draw_q  <= draw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (tbl_we) begin
      handles_q[base_nfs[SLOT_IDX_W-1:0]] <= item_q.texture_handle;
    end
  end

  `QBVE_ASSERT_NEVER(a_count_in_range, clk_i, rst_ni, count_q > COUNT_W'(INDEX_LIMIT))
  `QBVE_ASSERT_NEXT(a_draw_restarts_batch, clk_i, rst_ni, push_o && job_o.need_draw && is_quad, (count_q == COUNT_W'(INDICES_PER_QUAD)) && (nfs_q == NFS_W'(1) || nfs_q == NFS_W'(2)))

endmodule

>>> hw/rtl/qbve_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on qbve_pkg and the assertion macro header.
`include "quad_batch_vertex_expander_assert.svh"

module qbve_fifo import qbve_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   cnt_q;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_next(logic [QUEUE_PTR_W-1:0] p);
    ptr_next = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QUEUE_PTR_W + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (QUEUE_PTR_W + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  `QBVE_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `QBVE_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o)

endmodule

>>> hw/rtl/qbve_back.sv
// Back end: expands a queued command into draw, bind and corner results.
// Depends on qbve_pkg and the assertion macro header.
`include "quad_batch_vertex_expander_assert.svh"

module qbve_back import qbve_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [1:0] {
    PH_DRAW,
    PH_BIND,
    PH_VERT
  } phase_e;

  phase_e              phase_q, cur;
  logic [CORNER_W-1:0] corner_q;
  logic                out_valid_q, load, cu, cv;
  out_item_t           out_q, res;
  logic signed [COORD_W:0] sum_x, sum_y;

  function automatic logic [COORD_W-1:0] sat16(logic signed [COORD_W:0] s);
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat16 = s[COORD_W] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
    end else begin
      sat16 = s[COORD_W-1:0];
    end
  endfunction

  always_comb begin
    priority if (phase_q == PH_DRAW && job_i.need_draw) begin
      cur = PH_DRAW;
    end else if (phase_q != PH_VERT && job_i.need_bind) begin
      cur = PH_BIND;
    end else begin
      cur = PH_VERT;
    end
  end

  // Corner order is 00, 10, 11, 01 in (u, v).
  assign cu = corner_q[0] ^ corner_q[1];
  assign cv = corner_q[1];

  assign sum_x = {job_i.pos_x[COORD_W-1], job_i.pos_x} +
                 (cu ? {job_i.size_x[COORD_W-1], job_i.size_x} : '0);
  assign sum_y = {job_i.pos_y[COORD_W-1], job_i.pos_y} +
                 (cv ? {job_i.size_y[COORD_W-1], job_i.size_y} : '0);

  always_comb begin
    res = '0;
    unique case (cur)
      PH_DRAW: begin
        res.kind             = KIND_DRAW;
        res.draw_index_count = job_i.draw_count;
        res.last_result      = !job_i.is_quad;
      end
      PH_BIND: begin
        res.kind         = KIND_BIND;
        res.slot_number  = job_i.slot;
        res.bound_handle = job_i.handle;
      end
      PH_VERT: begin
        res.kind         = KIND_VERTEX;
        res.vertex_x     = sat16(sum_x);
        res.vertex_y     = sat16(sum_y);
        res.vertex_color = job_i.color;
        res.corner_u     = cu;
        res.corner_v     = cv;
        res.slot_number  = job_i.slot;
        res.last_result  = (corner_q == CORNER_W'(CORNERS - 1));
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign load        = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load && res.last_result;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DRAW;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      unique case (cur)
        PH_DRAW: begin
          phase_q <= job_i.is_quad ? PH_BIND : PH_DRAW;
        end
        PH_BIND: begin
          phase_q <= PH_VERT;
        end
        PH_VERT: begin
          if (res.last_result) begin
            phase_q  <= PH_DRAW;
            corner_q <= '0;
          end else begin
            phase_q  <= PH_VERT;
            corner_q <= corner_q + CORNER_W'(1);
          end
        end
        default: begin
          phase_q <= PH_DRAW;
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  `QBVE_ASSERT_IMP(a_vertex_phase_is_quad, clk_i, rst_ni, valid_i && phase_q == PH_VERT, job_i.is_quad)

endmodule

>>> hw/rtl/quad_batch_vertex_expander.sv
// Top level of the quad batch vertex expander.
// Depends on qbve_pkg, qbve_front, qbve_fifo and qbve_back.
//
// Usage:
//   Commands enter on in_item_i with in_valid_i/in_stall_o; a transfer takes
//   place at a rising edge where valid is high and stall is low. Results
//   leave on out_item_o with out_valid_o/out_stall_i in the same way.
//   A colored or textured quad yields four corner vertices, preceded by a
//   draw command when the batch is full and by a texture bind when the
//   texture has no slot yet. A flush yields one draw command. Opcode 3 is
//   taken and dropped without any result.
//   With an empty queue the first result of a command passes the front end's
//   capture, slot compare and enqueue states, the queue and the output register
//   before it appears on out_valid_o.
//   The front end takes a new command only after the last one has left its
//   states: capture, registered slot compare, then batch state update and
//   enqueue, which waits while the queue is full. The back end sends one result
//   per cycle while the receiver does not stall and the queue is not empty.
//   Reset clears the batch count to zero, the next free slot to one, and
//   empties the queue and the output register. Slot handles are not cleared;
//   only slots below the next free slot are ever compared.
//   While the receiver stalls, the output register holds its result, the
//   back end waits, the two-entry queue fills and then the front end stalls.
module quad_batch_vertex_expander import qbve_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Command transfer from the front end into the queue.
  logic push;
  logic queue_full;
  job_t front_job;

  // Queue head seen by the back end.
  logic pop;
  logic head_valid;
  job_t head_job;

  qbve_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .job_o        (front_job),
    .queue_full_i (queue_full)
  );

  qbve_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  qbve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> dv/quad_batch_vertex_expander_checker.sv
// Scoreboard for the quad batch vertex expander: watches both channels,
// predicts the result stream of every accepted command and compares it.
// Depends on qbve_pkg for the item types, kinds, opcodes and batch limits.
module quad_batch_vertex_expander_checker import qbve_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        mismatch_count_o,
  output int        pending_count_o,
  output int        checked_count_o,
  output int        draw_count_o,
  output int        bind_count_o
);

  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;

  // Mirror of the batch state.
  int unsigned batch_indices;
  int unsigned free_slot;
  logic [31:0] slot_table [64];

  out_item_t expected_results [$];
  out_item_t oldest;
  int        mismatches;
  int        checked;
  int        draws_seen;
  int        binds_seen;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = expected_results.size();
  assign checked_count_o  = checked;
  assign draw_count_o     = draws_seen;
  assign bind_count_o     = binds_seen;

  function automatic logic signed [COORD_W-1:0] corner_sum(
      logic signed [COORD_W-1:0] base, logic signed [COORD_W-1:0] extent, logic take);
    int s;
    s = int'(base) + (take ? int'(extent) : 0);
    if (s > COORD_MAX) s = COORD_MAX;
    else if (s < COORD_MIN) s = COORD_MIN;
    return s[COORD_W-1:0];
  endfunction

  // A draw closes the batch: its count goes out and the slots start over.
  function automatic void close_batch(logic last);
    out_item_t r;
    r                  = '0;
    r.kind             = KIND_DRAW;
    r.draw_index_count = batch_indices[DRAW_COUNT_W-1:0];
    r.last_result      = last;
    expected_results.push_back(r);
    batch_indices = 0;
    free_slot     = 1;
  endfunction

  function automatic void expand_command(in_item_t cmd);
    out_item_t   r;
    int unsigned slot;
    logic [31:0] color;
    logic        found;
    case (cmd.opcode)
      OP_FLUSH: begin
        close_batch(1'b1);
      end
      OP_COLORED, OP_TEXTURED: begin
        if (batch_indices >= INDEX_LIMIT ||
            (cmd.opcode == OP_TEXTURED && free_slot >= MAX_SLOTS)) begin
          close_batch(1'b0);
        end
        slot = 0;
        if (cmd.opcode == OP_COLORED) begin
          color = {cmd.color_red, cmd.color_green, cmd.color_blue, cmd.color_alpha};
        end else begin
          color = WHITE;
          found = 1'b0;
          for (int i = 1; i < free_slot && i < 64; i++) begin
            if (!found && slot_table[i] == cmd.texture_handle) begin
              slot  = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            // A texture without a slot gets the next one and a bind goes out.
            slot             = free_slot & 63;
            slot_table[slot] = cmd.texture_handle;
            free_slot        = (free_slot + 1) & 63;
            r                = '0;
            r.kind           = KIND_BIND;
            r.slot_number    = slot[SLOT_W-1:0];
            r.bound_handle   = cmd.texture_handle;
            expected_results.push_back(r);
          end
        end
        for (int k = 0; k < CORNERS; k++) begin
          r              = '0;
          r.kind         = KIND_VERTEX;
          r.corner_u     = (k == 1 || k == 2);
          r.corner_v     = (k >= 2);
          r.vertex_x     = corner_sum(cmd.pos_x, cmd.size_x, r.corner_u);
          r.vertex_y     = corner_sum(cmd.pos_y, cmd.size_y, r.corner_v);
          r.vertex_color = color;
          r.slot_number  = slot[SLOT_W-1:0];
          r.last_result  = (k == CORNERS - 1);
          expected_results.push_back(r);
        end
        batch_indices += INDICES_PER_QUAD;
      end
      default: begin
        // The spare opcode is dropped without effect.
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch on result %0d: expected 0x%0h, actual 0x%0h",
             name, checked, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_indices = 0;
      free_slot     = 1;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expand_command(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result of kind %0d arrived with nothing expected", out_item_i.kind);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", oldest.kind, out_item_i.kind);
          check_field("vertex_x", oldest.vertex_x, out_item_i.vertex_x);
          check_field("vertex_y", oldest.vertex_y, out_item_i.vertex_y);
          check_field("vertex_color", oldest.vertex_color, out_item_i.vertex_color);
          check_field("corner_u", oldest.corner_u, out_item_i.corner_u);
          check_field("corner_v", oldest.corner_v, out_item_i.corner_v);
          check_field("slot_number", oldest.slot_number, out_item_i.slot_number);
          check_field("bound_handle", oldest.bound_handle, out_item_i.bound_handle);
          check_field("draw_index_count", oldest.draw_index_count,
                      out_item_i.draw_index_count);
          check_field("last_result", oldest.last_result, out_item_i.last_result);
          if (oldest.kind == KIND_DRAW) draws_seen++;
          if (oldest.kind == KIND_BIND) binds_seen++;
        end
        checked++;
      end
    end
  end

endmodule

>>> dv/tb.sv
// Top of the quad batch vertex expander testbench: clock, reset, command
// stimulus, result-side stalls and the verdict.
// Depends on qbve_pkg, the block and quad_batch_vertex_expander_checker.
module tb import qbve_pkg::*; ();

  // The spare opcode value; the block has to drop it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Far above the slowest legal run: about 330 commands of up to six
  // results, each result waiting out random stalls, plus the long hold-off.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_SIZE = 48;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int draw_count;
  int bind_count;

  // Idle rates in percent of cycles, changed between phases.
  int unsigned sender_idle_pct   = 26;
  int unsigned receiver_idle_pct = 59;

  // The stimulus asks once for a long receiver hold-off; the receiver
  // process counts it out on its own.
  bit hold_off_go    = 1'b0;
  bit hold_off_taken = 1'b0;
  int hold_left      = 0;

  int          cycle_count   = 0;
  int          commands_sent = 0;
  logic [31:0] handle_pool [POOL_SIZE];

  quad_batch_vertex_expander dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  quad_batch_vertex_expander_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count),
    .draw_count_o     (draw_count),
    .bind_count_o     (bind_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side. Outside the hold-off the stall follows the current idle
  // rate. During the hold-off the sender keeps offering commands, so the
  // output register and the two-entry queue fill and the block stalls its
  // input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_off_go && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      hold_left      <= HOLD_OFF_CYCLES;
      out_stall_i    <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run timed out after %0d cycles with %0d results outstanding",
           cycle_count, pending_count);
    $display("tb: failure");
    $finish;
  end

  // Offers one command and returns right after the edge of its transfer.
  // Each step gets a single assignment to in_valid_i, so a valid that stays
  // high from one command to the next is never dropped in between.
  task automatic send_command(in_item_t cmd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    commands_sent++;
  endtask

  function automatic in_item_t make_quad(logic [1:0] op,
      logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] sx, logic signed [15:0] sy,
      logic [31:0] rgba, logic [31:0] handle);
    in_item_t c;
    c.opcode         = op;
    c.pos_x          = px;
    c.pos_y          = py;
    c.size_x         = sx;
    c.size_y         = sy;
    {c.color_red, c.color_green, c.color_blue, c.color_alpha} = rgba;
    c.texture_handle = handle;
    return c;
  endfunction

  // Coordinates lean on the saturation edges but cover the whole range.
  function automatic logic signed [15:0] random_coord();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_command(int unsigned tex_pct,
      int unsigned flush_pct, int unsigned pool_span);
    in_item_t    c;
    int unsigned roll;
    logic [31:0] handle;
    logic [1:0]  op;
    handle = ($urandom_range(19) == 0) ? $urandom : handle_pool[$urandom_range(pool_span - 1)];
    roll = $urandom_range(99);
    if (roll < 4) op = OP_UNUSED;
    else if (roll < 4 + flush_pct) op = OP_FLUSH;
    else if (roll < 4 + flush_pct + tex_pct) op = OP_TEXTURED;
    else op = OP_COLORED;
    c = make_quad(op, random_coord(), random_coord(), random_coord(), random_coord(),
                  $urandom, handle);
    return c;
  endfunction

  // Random commands in runs that share a texture mix: a narrow handle span
  // gives mostly slot hits, the full pool gives misses and, on long runs
  // without a flush, exhausts the slots. Dropped commands do not count.
  task automatic run_random(int unsigned n_items);
    int unsigned counted;
    int unsigned run_len;
    int unsigned tex_pct;
    int unsigned flush_pct;
    int unsigned span;
    in_item_t    cmd;
    counted = 0;
    while (counted < n_items) begin
      run_len   = $urandom_range(60, 5);
      tex_pct   = $urandom_range(90, 10);
      flush_pct = $urandom_range(6);
      span      = $urandom_range(1) ? POOL_SIZE : $urandom_range(6, 1);
      for (int i = 0; i < run_len && counted < n_items; i++) begin
        cmd = random_command(tex_pct, flush_pct, span);
        send_command(cmd);
        if (cmd.opcode != OP_UNUSED) counted++;
      end
    end
  endtask

  initial begin
    handle_pool[0] = 32'h0000_0000;
    handle_pool[1] = 32'hFFFF_FFFF;
    handle_pool[2] = 32'h0000_0001;
    for (int i = 3; i < POOL_SIZE; i++) handle_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: the sender idles lightly, the receiver heavily.
    sender_idle_pct   = 26;
    receiver_idle_pct = 59;

    // Directed part. A flush of an empty batch still draws, with count 0.
    send_command(make_quad(OP_FLUSH, '0, '0, '0, '0, '0, '0));
    // Corner sums saturating upward, downward, and a mixed sum that fits.
    send_command(make_quad(OP_COLORED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                           32'hFFFF_FFFF, '0));
    send_command(make_quad(OP_COLORED, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                           32'h0000_0000, 32'hFFFF_FFFF));
    send_command(make_quad(OP_COLORED, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                           32'h12AB_CD34, '0));
    send_command(make_quad(OP_COLORED, 16'sh0100, -16'sh0080, 16'sh0000, 16'sh0000,
                           32'h8040_2010, '0));
    // Texture misses allocate slots and bind; a repeat is a hit without one.
    send_command(make_quad(OP_TEXTURED, 16'sh0010, 16'sh0020, 16'sh0100, 16'sh0100,
                           32'hFFFF_FFFF, handle_pool[0]));
    send_command(make_quad(OP_TEXTURED, 16'sh7F00, 16'sh8100, 16'sh0200, -16'sh0200,
                           '0, handle_pool[0]));
    send_command(make_quad(OP_TEXTURED, -16'sh0001, 16'sh0000, 16'sh7FFF, 16'sh7FFF,
                           '0, handle_pool[1]));
    send_command(make_quad(OP_TEXTURED, 16'sh0000, -16'sh0001, 16'sh8000, 16'sh8000,
                           '0, handle_pool[0]));
    // The spare opcode is taken and dropped, whatever the payload.
    send_command(make_quad(OP_UNUSED, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_command(make_quad(OP_COLORED, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001,
                           32'h0102_0304, '0));
    send_command(make_quad(OP_FLUSH, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // Slot exhaustion: fill every texture slot. A colored quad then goes in
    // without a draw, but the next textured quad, even one that would hit,
    // needs a draw first and then binds again from slot one.
    for (int i = 1; i < MAX_SLOTS; i++) begin
      send_command(make_quad(OP_TEXTURED, random_coord(), random_coord(), random_coord(),
                             random_coord(), '0, 32'hA500_0000 + i));
    end
    send_command(make_quad(OP_COLORED, 16'sh0040, 16'sh0040, 16'sh0040, 16'sh0040,
                           32'hDEAD_BEEF, '0));
    send_command(make_quad(OP_TEXTURED, 16'sh0040, 16'sh0040, 16'sh0040, 16'sh0040,
                           '0, 32'hA500_0001));

    // Random part under pressure: the receiver holds off for a long stretch
    // right at its start.
    hold_off_go = 1'b1;
    run_random(90);

    // Phase two: the idle rates swap.
    sender_idle_pct   = 59;
    receiver_idle_pct = 26;
    run_random(90);

    // Phase three: no idling at all.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(90);

    in_valid_i <= 1'b0;
    // The wait below lets the last transfer reach the checker before its
    // outstanding count is trusted.
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d commands sent, %0d results checked, %0d draws, %0d binds",
             commands_sent, checked_count, draw_count, bind_count);
    $display("summary: saturation edges, slot hits and misses, slot exhaustion, spare opcode");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
